FILE: rtl/core/hufd_pkg.sv
package hufd_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned ENTRY_W     = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SYM_W       = 15;
  localparam int unsigned TE_W        = 11;
  localparam int unsigned WC_W        = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // Bits consumed from one data byte, and the counter that walks them.
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE);

  // Symbols from this code upward may be dictionary words.
  localparam logic [SYM_W-1:0] SYM_WORD_BASE = 15'h0080;

  // Operation carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_DECODE = 2'd2
  } op_e;

  // Kind of a result item.
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_WORD = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_ENTRIES = 1'b0,
    CFG_WORD_COUNT    = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/core/hufd_table_ram.sv
module hufd_table_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic [hufd_pkg::ENTRY_W-1:0]     wdata_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic [hufd_pkg::ENTRY_W-1:0]     rdata_o
);
  import hufd_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  // One write port and one read port; read data arrives the cycle after.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/huffman_table_text_decoder_core.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  op, table_addr, table_value, data_byte
// out       output     out_valid_o/out_ready_i kind, value, last
// cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A table write or a start leaves the block idle. A data byte holds the input side
// while the block reads the table, one read per code bit, each address formed from
// the previous read, then releases the final result.
// An output stall holds the walk only when a new symbol meets a full result path.
// Reset clears control state at once; the code table is undefined until written.
module huffman_table_text_decoder_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hufd_pkg::OP_W-1:0]           in_op_i,
  input  logic [hufd_pkg::ADDR_W-1:0]         in_table_addr_i,
  input  logic signed [hufd_pkg::ENTRY_W-1:0] in_table_value_i,
  input  logic [hufd_pkg::DATA_W-1:0]         in_data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hufd_pkg::KIND_W-1:0]         out_kind_o,
  output logic [hufd_pkg::SYM_W-1:0]          out_value_o,
  output logic                                out_last_o,
  input  logic                                cfg_we_i,
  input  logic [hufd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hufd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import hufd_pkg::*;

  // Node index width; the depth is a power of two, so wrapping keeps the low bits.
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned XW = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int unsigned RW = (AW > TE_W) ? AW : TE_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          cur_node_q, cur_node_d;
  logic                   done_q, done_d;
  logic [DATA_W-2:0]      byte_q, byte_d;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]          raddr_q, raddr_d;
  logic                   pend_v_q, pend_v_d;
  logic [KIND_W-1:0]      pend_kind_q, pend_kind_d;
  logic [SYM_W-1:0]       pend_value_q, pend_value_d;
  logic [TE_W-1:0]        te_q;
  logic [WC_W-1:0]        wc_q;
  logic                   out_v_q, out_v_d;
  logic [KIND_W-1:0]      out_kind_q;
  logic [SYM_W-1:0]       out_value_q;
  logic                   out_last_q;

  logic                   ram_we;
  logic [XW-1:0]          waddr_x;
  logic [ENTRY_W-1:0]     entry;
  logic                   is_leaf;
  logic [SYM_W-1:0]       sym;
  logic [SYM_W-1:0]       word_off;
  logic [KIND_W-1:0]      leaf_kind;
  logic [SYM_W-1:0]       leaf_value;
  logic [RW-1:0]          root_x;
  logic [AW-1:0]          root;
  logic [AW-1:0]          node_n;
  logic                   out_ok;
  logic                   walk_stall;
  logic                   push;
  logic                   push_last;

  assign waddr_x = XW'(in_table_addr_i);

  // The code table: written by table items, read once per code bit.
  hufd_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_x[AW-1:0]),
    .wdata_i (in_table_value_i),
    .raddr_i (raddr_d),
    .rdata_o (entry)
  );

  // Root node wraps modulo the table depth.
  assign root_x = RW'(te_q) - RW'(2);
  assign root   = root_x[AW-1:0];

  // Leaf symbol is the bitwise complement of the entry; classify it.
  assign is_leaf  = entry[ENTRY_W-1];
  assign sym      = ~entry[SYM_W-1:0];
  assign word_off = sym - SYM_WORD_BASE;

  always_comb begin
    if (sym == '0) begin
      leaf_kind  = KIND_END;
      leaf_value = '0;
    end else if ((sym < SYM_WORD_BASE) || (WC_W'(word_off) >= wc_q)) begin
      leaf_kind  = KIND_CHAR;
      leaf_value = sym;
    end else begin
      leaf_kind  = KIND_WORD;
      leaf_value = word_off;
    end
  end

  assign out_ok     = !out_v_q || out_ready_i;
  assign walk_stall = is_leaf && pend_v_q && !out_ok;

  // Sequencer: accept items, walk the table one bit a cycle unless stalled, then flush.
  // The last symbol of a byte waits in a pending slot until its last flag is known.
  always_comb begin
    state_d      = state_q;
    cur_node_d   = cur_node_q;
    done_d       = done_q;
    byte_d       = byte_q;
    cnt_d        = cnt_q;
    raddr_d      = raddr_q;
    pend_v_d     = pend_v_q;
    pend_kind_d  = pend_kind_q;
    pend_value_d = pend_value_q;
    ram_we       = 1'b0;
    push         = 1'b0;
    push_last    = 1'b0;
    node_n       = cur_node_q;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // The first read goes out with the accepting edge.
        raddr_d = cur_node_q | AW'(in_data_byte_i[0]);
        if (in_valid_i) begin
          case (in_op_i)
            OP_WRITE: begin
              ram_we = 1'b1;
            end
            OP_START: begin
              cur_node_d = root;
              done_d     = 1'b0;
            end
            OP_DECODE: begin
              if (!done_q) begin
                state_d = ST_WALK;
                byte_d  = in_data_byte_i[DATA_W-1:1];
                cnt_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        if (!walk_stall) begin
          if (is_leaf) begin
            node_n = root;
            if (pend_v_q) begin
              push = 1'b1;
            end
            pend_v_d     = 1'b1;
            pend_kind_d  = leaf_kind;
            pend_value_d = leaf_value;
            if (sym == '0) begin
              done_d = 1'b1;
            end
          end else begin
            node_n = entry[AW-1:0];
          end
          cur_node_d = node_n;
          if ((is_leaf && (sym == '0)) || (cnt_q == BIT_CNT_W'(BITS_PER_BYTE - 1))) begin
            state_d = ST_FLUSH;
          end else begin
            raddr_d = node_n | AW'(byte_q[0]);
            byte_d  = byte_q >> 1;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (pend_v_q) begin
          if (out_ok) begin
            push      = 1'b1;
            push_last = 1'b1;
            pend_v_d  = 1'b0;
            state_d   = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_v_d = push ? 1'b1 : (out_ready_i ? 1'b0 : out_v_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_node_q <= '0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      te_q       <= TE_W'(2);
      wc_q       <= '0;
    end else begin
      state_q    <= state_d;
      cur_node_q <= cur_node_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TABLE_ENTRIES: te_q <= cfg_wdata_i[TE_W-1:0];
          CFG_WORD_COUNT:    wc_q <= cfg_wdata_i[WC_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    raddr_q      <= raddr_d;
    pend_kind_q  <= pend_kind_d;
    pend_value_q <= pend_value_d;
    if (push) begin
      out_kind_q  <= pend_kind_q;
      out_value_q <= pend_value_q;
      out_last_q  <= push_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/core/hufd_checker.sv
module hufd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic [hufd_pkg::OP_W-1:0]           in_op_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [hufd_pkg::KIND_W-1:0]         out_kind_o,
  input  logic [hufd_pkg::SYM_W-1:0]          out_value_o,
  input  logic                                out_last_o
);
  import hufd_pkg::*;

  // A stalled result item holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_kind_o) && $stable(out_value_o) && $stable(out_last_o))
    else $error("stalled result item changed");

  // End of message carries zero and closes the results of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_END) |-> (out_value_o == '0) && out_last_o)
    else $error("end of message item malformed");

  // A word index never exceeds the largest symbol minus the word base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KIND_WORD) |-> (out_value_o < ~SYM_WORD_BASE + 1'b1))
    else $error("word index out of range");

  // Table writes and starts leave the block ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && ((in_op_i == OP_WRITE) || (in_op_i == OP_START)) |=>
      in_ready_o)
    else $error("block busy after a table write or start");

endmodule

bind huffman_table_text_decoder_core hufd_checker u_hufd_checker (.*);

FILE: dv/tb_huffman_table_text_decoder_core.sv
`timescale 1ns / 100ps

module tb_huffman_table_text_decoder_core;
  import hufd_pkg::*;

  // Operation code that the block must ignore.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  // Marks a stimulus row whose results come from the decoder model below.
  localparam int PREDICTED = -1;
  localparam int DIR_ROWS = 27;
  localparam int IDLE_GAP = 16;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_MODE = 27;

  // One stimulus row: an input item, or a register write when is_cfg is set.
  // For a register write, addr[0] carries the register index and value the data.
  typedef struct packed {
    logic               is_cfg;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] value;
    logic [DATA_W-1:0]  data;
    int                 exp_n;
    kind_e              exp_kind;
    logic [SYM_W-1:0]   exp_val;
  } step_t;

  // One decoded symbol as it leaves the block.
  typedef struct packed {
    kind_e            kind;
    logic [SYM_W-1:0] value;
    logic             last;
  } sym_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  step_t                 offered = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [KIND_W-1:0]     out_kind_o;
  logic [SYM_W-1:0]      out_value_o;
  logic                  out_last_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Decoder model state and its copy of the registers.
  logic [ENTRY_W-1:0] code_mem [1024];
  logic [ADDR_W-1:0]  walk_node = '0;
  logic               msg_ended = 1'b0;
  logic [TE_W-1:0]    n_entries = 11'd2;
  logic [WC_W-1:0]    n_words = '0;
  sym_res_t           want_syms [$];

  step_t       directed [DIR_ROWS];
  int unsigned items_sent = 0;
  int          mismatches = 0;
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_rx = 1'b0;
  int          quiet_cycles = 0;
  int          base_cnt;
  int          res_i;
  sym_res_t    head;

  huffman_table_text_decoder_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_op_i         (offered.op),
    .in_table_addr_i (offered.addr),
    .in_table_value_i(offered.value),
    .in_data_byte_i  (offered.data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_o      (out_kind_o),
    .out_value_o     (out_value_o),
    .out_last_o      (out_last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Models one item; a data byte walks the code table and queues its symbols.
  function automatic void decode_item(input step_t it);
    logic [ADDR_W-1:0]  root_node;
    logic [ADDR_W-1:0]  slot;
    logic [ENTRY_W-1:0] entry;
    logic [SYM_W-1:0]   sym;
    logic [DATA_W-1:0]  bits;
    int                 first;
    int                 b;
    root_node = n_entries[ADDR_W-1:0] - 10'd2;
    first = want_syms.size();
    case (it.op)
      OP_WRITE: code_mem[it.addr] = it.value;
      OP_START: begin
        walk_node = root_node;
        msg_ended = 1'b0;
      end
      OP_DECODE: begin
        if (!msg_ended) begin
          bits = it.data;
          for (b = 0; b < BITS_PER_BYTE; b++) begin
            slot = {walk_node[ADDR_W-1:1], walk_node[0] | bits[0]};
            entry = code_mem[slot];
            bits = bits >> 1;
            if (!entry[ENTRY_W-1]) begin
              walk_node = entry[ADDR_W-1:0];
            end else begin
              // A leaf holds the symbol inverted; the walk restarts at the root.
              sym = ~entry[SYM_W-1:0];
              walk_node = root_node;
              if (sym == '0) begin
                want_syms.push_back('{kind: KIND_END, value: '0, last: 1'b0});
                msg_ended = 1'b1;
                break;
              end else if (sym < SYM_WORD_BASE ||
                           int'(sym) - int'(SYM_WORD_BASE) >= int'(n_words)) begin
                want_syms.push_back('{kind: KIND_CHAR, value: sym, last: 1'b0});
              end else begin
                want_syms.push_back('{kind: KIND_WORD, value: sym - SYM_WORD_BASE,
                                      last: 1'b0});
              end
            end
          end
          if (want_syms.size() > first) want_syms[want_syms.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Scoreboard: register writes, accepted items and results, plus the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TABLE_ENTRIES: n_entries = cfg_wdata_i[TE_W-1:0];
          CFG_WORD_COUNT:    n_words = cfg_wdata_i[WC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (want_syms.size() == 0) begin
          note_mismatch($sformatf("result kind %0d value 0x%0h with nothing pending",
                                  out_kind_o, out_value_o));
        end else begin
          head = want_syms.pop_front();
          if (out_kind_o !== head.kind || out_value_o !== head.value ||
              out_last_o !== head.last) begin
            note_mismatch($sformatf("got kind %0d value 0x%0h last %0b, want %0d 0x%0h %0b",
                                    out_kind_o, out_value_o, out_last_o,
                                    head.kind, head.value, head.last));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        base_cnt = want_syms.size();
        decode_item(offered);
        // Rows with typed results replace what the model queued for them.
        if (offered.exp_n != PREDICTED) begin
          while (want_syms.size() > base_cnt) void'(want_syms.pop_back());
          for (res_i = 0; res_i < offered.exp_n; res_i++) begin
            want_syms.push_back('{kind: offered.exp_kind, value: offered.exp_val,
                                  last: res_i == offered.exp_n - 1});
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, with one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offers one item, with random gaps ahead of it; returns at a falling edge.
  task automatic send(input step_t it);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    offered <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Stops offering and waits until every pending symbol has come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (want_syms.size() != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic step_t item_of(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                    input logic [ENTRY_W-1:0] value,
                                    input logic [DATA_W-1:0] data);
    step_t it;
    it = '0;
    it.op = op;
    it.addr = addr;
    it.value = value;
    it.data = data;
    it.exp_n = PREDICTED;
    it.exp_kind = KIND_CHAR;
    return it;
  endfunction

  // Mix of characters, words around the word count, wide codes and end codes.
  function automatic logic [SYM_W-1:0] pick_symbol(input bit allow_end);
    int r;
    int span;
    r = $urandom_range(99);
    span = (n_words > 16'd200) ? 200 : int'(n_words) + 2;
    if (allow_end && r < 8) return '0;
    if (r < 50) return SYM_W'($urandom_range(1, 127));
    if (r < 80) return SYM_W'(128 + $urandom_range(0, span));
    return SYM_W'($urandom_range(1, 32767));
  endfunction

  // Builds a random code tree whose nodes sit at the root and below it, two
  // apart. Each node slot is a leaf or a pointer to an earlier node, so every
  // reachable slot has been written. Nodes at odd addresses have one slot.
  task automatic load_tree(input logic [ADDR_W-1:0] root, input int nodes,
                           input bit allow_end);
    logic [ADDR_W-1:0]  node_addr;
    logic [ENTRY_W-1:0] entry;
    logic [ADDR_W-1:0]  subtrees [$];
    int                 k;
    int                 s;
    int                 pick;
    for (k = 0; k < nodes; k++) begin
      node_addr = root - ADDR_W'(2 * (nodes - 1 - k));
      for (s = 0; s <= (node_addr[0] ? 0 : 1); s++) begin
        if (subtrees.size() > 0 && $urandom_range(99) < 55) begin
          pick = $urandom_range(subtrees.size() - 1);
          // Pointers carry random bits above the node index; they wrap away.
          entry = {1'b0, 5'($urandom), subtrees[pick]};
          subtrees.delete(pick);
        end else begin
          entry = ~{1'b0, pick_symbol(allow_end)};
        end
        send(item_of(OP_WRITE, node_addr | ADDR_W'(s), entry, DATA_W'($urandom)));
      end
      subtrees.push_back(node_addr);
    end
  endtask

  // One message: registers, a fresh tree, usually a start, then data bytes
  // with stray starts and ignored items mixed in.
  task automatic run_message(input logic [TE_W-1:0] te, input logic [WC_W-1:0] wc,
                             input int n_bytes, input bit squeeze);
    int k;
    int r;
    wait_idle();
    write_cfg(CFG_TABLE_ENTRIES, CFG_DATA_W'(te));
    write_cfg(CFG_WORD_COUNT, wc);
    load_tree(te[ADDR_W-1:0] - 10'd2, squeeze ? 6 : $urandom_range(1, 7), !squeeze);
    if (squeeze || $urandom_range(99) < 85) begin
      send(item_of(OP_START, ADDR_W'($urandom), ENTRY_W'($urandom), DATA_W'($urandom)));
    end
    // The result side holds off while bytes keep coming, so the block backs up.
    if (squeeze) hold_rx = 1'b1;
    for (k = 0; k < n_bytes; k++) begin
      r = $urandom_range(99);
      if (!squeeze && r < 5) begin
        send(item_of(OP_IGNORED, ADDR_W'($urandom), ENTRY_W'($urandom), DATA_W'($urandom)));
      end else if (!squeeze && r < 15) begin
        send(item_of(OP_START, ADDR_W'($urandom), ENTRY_W'($urandom), DATA_W'($urandom)));
      end else begin
        send(item_of(OP_DECODE, ADDR_W'($urandom), ENTRY_W'($urandom), DATA_W'($urandom)));
      end
    end
  endtask

  initial begin
    int              row;
    int              mode;
    int              phase_no;
    int unsigned     mode_start;
    logic [TE_W-1:0] te;
    logic [WC_W-1:0] wc;
    bit              squeezed;

    // Directed rows. Leaves hold the inverted symbol: 'A' is FFBE, the widest
    // symbol 8000, the end code FFFF, 0x80 and 0x81 are FF7F and FF7E.
    directed = '{
      // Decoding before any start walks from node zero; every bit is a leaf.
      '{1'b0, OP_WRITE,   10'd0,    16'hFFBE, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_WRITE,   10'd1,    16'h8000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h00, 8,         KIND_CHAR, 15'h0041},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'hFF, 8,         KIND_CHAR, 15'h7FFF},
      '{1'b0, OP_IGNORED, 10'd0,    16'h0000, 8'h00, 0,         KIND_CHAR, 15'h0},
      // End code mid byte; later bytes are dropped until a start.
      '{1'b0, OP_WRITE,   10'd1,    16'hFFFF, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h02, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h5A, 0,         KIND_CHAR, 15'h0},
      '{1'b0, OP_START,   10'd0,    16'h0000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'hFE, PREDICTED, KIND_CHAR, 15'h0},
      // Word count boundary: 0x80 is a word, 0x81 is a character.
      '{1'b1, OP_WRITE,   10'(CFG_WORD_COUNT), 16'd1, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_WRITE,   10'd0,    16'hFF7F, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_WRITE,   10'd1,    16'hFF7E, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_START,   10'd0,    16'h0000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'hAA, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b1, OP_WRITE,   10'(CFG_WORD_COUNT), 16'hFFFF, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_WRITE,   10'd1,    16'h8000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h55, PREDICTED, KIND_CHAR, 15'h0},
      // Two levels: root 2 points at node 0 with high bits set; codes span bytes.
      '{1'b1, OP_WRITE,   10'(CFG_TABLE_ENTRIES), 16'd4, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_WRITE,   10'd2,    16'h7C00, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_WRITE,   10'd3,    16'hFF85, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_START,   10'd0,    16'h0000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h01, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h03, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_START,   10'd0,    16'h0000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      '{1'b0, OP_DECODE,  10'd0,    16'h0000, 8'h00, PREDICTED, KIND_CHAR, 15'h0},
      // Top address with the largest positive entry; a self loop never reached.
      '{1'b0, OP_WRITE,   10'd1023, 16'h7FFF, 8'h00, PREDICTED, KIND_CHAR, 15'h0}
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    tx_gap_pct = 34;
    rx_stall_pct = 51;
    for (row = 0; row < DIR_ROWS; row++) begin
      if (directed[row].is_cfg) begin
        wait_idle();
        write_cfg(cfg_idx_e'(directed[row].addr[0]), directed[row].value);
      end else begin
        send(directed[row]);
      end
    end

    // Random messages under three idling patterns. Early messages use the
    // table size extremes, including sizes whose root wraps around.
    phase_no = 0;
    squeezed = 1'b0;
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_gap_pct = 34;
          rx_stall_pct = 51;
        end
        1: begin
          tx_gap_pct = 51;
          rx_stall_pct = 34;
        end
        default: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      mode_start = items_sent;
      while (items_sent - mode_start < ITEMS_PER_MODE) begin
        case (phase_no)
          0: te = 11'd2;
          1: te = 11'd1024;
          2: te = 11'd0;
          3: te = 11'd1;
          4: te = 11'd2047;
          5: te = 11'd1026;
          default: te = TE_W'($urandom_range(2, 1024));
        endcase
        case ($urandom_range(3))
          0: wc = '0;
          1: wc = '1;
          2: wc = WC_W'($urandom_range(0, 40));
          default: wc = WC_W'($urandom);
        endcase
        if (mode == 2 && !squeezed) begin
          run_message(te, wc, 16, 1'b1);
          squeezed = 1'b1;
        end else begin
          run_message(te, wc, $urandom_range(6, 14), 1'b0);
        end
        phase_no++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
